// ----- sv/sobel_pkg.sv -----
// Shared types and constants for the Sobel edge detector.
package sobel_pkg;

    localparam int PIXEL_BITS = 8;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 11;
    localparam int SQ_W       = 22;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS + 1);
    localparam int CFG_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int OUT_DATA_W = 40;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic shift;
        logic grad;
        logic sq_x;
        logic sq_sum;
        logic sqrt_step;
        logic load_out;
    } sobel_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_last;
        logic out_free;
    } sobel_stat_t;

endpackage

// ----- sv/sobel_edge_detector_top.sv -----
// Top level of the streaming 3x3 Sobel edge detector.
// The square root loop runs 11 steps for each pixel.
// A new pixel is taken once the previous result sits in the output register.
// Reset (aresetn, synchronous, active low) clears counters, window, control
// and sets both size registers to 1024; line stores are not cleared.
module sobel_edge_detector_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sobel_pkg::PIXEL_BITS-1:0]    s_tdata,  // [7:0] pixel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sobel_pkg::OUT_DATA_W-1:0]    m_tdata,  // grad_x, grad_y, magnitude
    output logic                                m_tlast,  // frame_end
    output logic                                m_tuser   // valid_res
);
    import sobel_pkg::*;

    sobel_cmd_t  cmd;
    sobel_stat_t stat;

    sobel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sobel_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .pixel     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // One pixel at a time: no new transaction right after one is taken.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a pixel is in flight");

    // Without a full window the gradient fields are zero.
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("nonzero result without a full window");

    // No result comes out of reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A result only follows a pixel: none appears while waiting for input.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without a pixel");

endmodule

// ----- sv/sobel_ctrl.sv -----
// Controller state machine that sequences one pixel through the datapath.
module sobel_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sobel_pkg::sobel_stat_t stat,
    output sobel_pkg::sobel_cmd_t  cmd
);
    import sobel_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SHIFT, ST_GRAD, ST_SQX, ST_SQS, ST_SQRT, ST_DONE
    } state_t;

    state_t state_reg;

    assign s_tready = (state_reg == ST_IDLE);

    // Decode commands from the current state.
    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.capture   = s_tvalid;
            ST_SHIFT: cmd.shift     = 1'b1;
            ST_GRAD:  cmd.grad      = 1'b1;
            ST_SQX:   cmd.sq_x      = 1'b1;
            ST_SQS:   cmd.sq_sum    = 1'b1;
            ST_SQRT:  cmd.sqrt_step = 1'b1;
            ST_DONE:  cmd.load_out  = stat.out_free;
            default:  cmd = '0;
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE:  if (s_tvalid) state_reg <= ST_SHIFT;
                ST_SHIFT: state_reg <= ST_GRAD;
                ST_GRAD:  state_reg <= ST_SQX;
                ST_SQX:   state_reg <= ST_SQS;
                ST_SQS:   state_reg <= ST_SQRT;
                ST_SQRT:  if (stat.sqrt_last) state_reg <= ST_DONE;
                ST_DONE:  if (stat.out_free) state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- sv/sobel_dp.sv -----
// Datapath: counters, line stores, window, gradients, square root and output register.
module sobel_dp #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic                                cfg_idx,
    input  logic [sobel_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [sobel_pkg::PIXEL_BITS-1:0]    pixel,
    input  sobel_pkg::sobel_cmd_t               cmd,
    output sobel_pkg::sobel_stat_t              stat,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [sobel_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);
    import sobel_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    logic [WIDTH_W-1:0]    width_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [COL_W-1:0]      col_reg, cur_col_reg;
    logic [HEIGHT_W-1:0]   row_reg;
    logic [PIXEL_BITS-1:0] px_reg;
    logic                  valid_reg, fend_reg;
    logic [PIXEL_BITS-1:0] line1_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] line2_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd1_reg, rd2_reg;
    logic [PIXEL_BITS-1:0] win_reg [3][3];
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SQ_W-1:0]       sqx_reg, v_reg, res_reg, bit_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  m_tvalid_reg;

    // Effective frame geometry and end-of-row, end-of-frame decisions.
    logic [CMP_W-1:0]    w_ext, w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                last_col, last_row;

    always_comb begin
        w_ext = CMP_W'(width_reg);
        priority if (w_ext < CMP_W'(3)) begin
            w_eff = CMP_W'(3);
        end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        h_eff    = (height_reg < HEIGHT_W'(3)) ? HEIGHT_W'(3) : height_reg;
        last_col = CMP_W'(col_reg) >= (w_eff - CMP_W'(1));
        last_row = row_reg >= (h_eff - HEIGHT_W'(1));
    end

    // Configuration registers and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_W'(1024);
            height_reg <= HEIGHT_W'(1024);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_W-1:0];
                    default:          width_reg  <= width_reg;
                endcase
            end
            if (cmd.capture) begin
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + HEIGHT_W'(1);
                end else begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
        end
    end

    // Capture the incoming pixel and its flags.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            px_reg      <= pixel;
            cur_col_reg <= col_reg;
            valid_reg   <= (row_reg >= HEIGHT_W'(2)) && (col_reg >= COL_W'(2));
            fend_reg    <= last_col && last_row;
        end
    end

    // Line stores: read every cycle at the current column, written on shift.
    always_ff @(posedge aclk) begin
        rd1_reg <= line1_mem[col_reg];
        rd2_reg <= line2_mem[col_reg];
        if (cmd.shift) begin
            line1_mem[cur_col_reg] <= px_reg;
            line2_mem[cur_col_reg] <= rd1_reg;
        end
    end

    // Window shifts left and takes the new column on the right.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    win_reg[a][b] <= '0;
                end
            end
        end else if (cmd.shift) begin
            for (int a = 0; a < 3; a++) begin
                win_reg[a][0] <= win_reg[a][1];
                win_reg[a][1] <= win_reg[a][2];
            end
            win_reg[0][2] <= rd2_reg;
            win_reg[1][2] <= rd1_reg;
            win_reg[2][2] <= px_reg;
        end
    end

    // Sobel gradients as the difference of two non-negative weighted sums.
    logic [GRAD_W-1:0] xp, xn, yp, yn;

    always_comb begin
        xp = GRAD_W'(win_reg[0][2]) + (GRAD_W'(win_reg[1][2]) << 1) + GRAD_W'(win_reg[2][2]);
        xn = GRAD_W'(win_reg[0][0]) + (GRAD_W'(win_reg[1][0]) << 1) + GRAD_W'(win_reg[2][0]);
        yp = GRAD_W'(win_reg[2][0]) + (GRAD_W'(win_reg[2][1]) << 1) + GRAD_W'(win_reg[2][2]);
        yn = GRAD_W'(win_reg[0][0]) + (GRAD_W'(win_reg[0][1]) << 1) + GRAD_W'(win_reg[0][2]);
    end

    // Squares, one product per cycle, then the bit-pair square root.
    logic signed [2*GRAD_W-1:0] prod;
    logic [SQ_W-1:0]            trial;

    assign prod  = cmd.sq_x ? gx_reg * gx_reg : gy_reg * gy_reg;
    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.grad) begin
            gx_reg <= $signed(xp - xn);
            gy_reg <= $signed(yp - yn);
        end
        if (cmd.sq_x) begin
            sqx_reg <= SQ_W'(prod);
        end
        if (cmd.sq_sum) begin
            v_reg    <= sqx_reg + SQ_W'(prod);
            res_reg  <= '0;
            bit_reg  <= SQ_W'(1) << (SQ_W - 2);
            step_reg <= '0;
        end
        if (cmd.sqrt_step) begin
            if (v_reg >= trial) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign stat.sqrt_last = (step_reg == STEP_W'(SQRT_STEPS - 1));
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    // Output register; fields are zero when no full window lies behind the pixel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (valid_reg) begin
                m_tdata <= {{(OUT_DATA_W - 2*GRAD_W - MAG_W){1'b0}},
                            res_reg[MAG_W-1:0], gy_reg, gx_reg};
            end else begin
                m_tdata <= '0;
            end
            m_tuser <= valid_reg;
            m_tlast <= fend_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- tb/sv/sobel_edge_detector_top_test.sv -----
// Self-checking testbench for the streaming 3x3 Sobel edge detector.
`timescale 1ns / 100ps

module sobel_edge_detector_top_test;
    import sobel_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int LIMIT_CYCLE = 900000;
    localparam int LATENCY     = 40;

    // One expected result.
    typedef struct packed {
        logic                   valid_res;
        logic [GRAD_W-1:0]      grad_x;
        logic [GRAD_W-1:0]      grad_y;
        logic [MAG_W-1:0]       magnitude;
        logic                   frame_end;
    } sobel_res_t;

    // One directed stimulus row; has_exp marks rows with a typed-in result.
    typedef struct {
        logic [7:0] pixel;
        bit         has_exp;
        sobel_res_t exp_res;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic                   cfg_idx;
    logic [CFG_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIXEL_BITS-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    sobel_edge_detector_top #(.MAX_WIDTH(MAX_W)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // Predictor state: mirrors of the size registers, line stores, window and counters.
    logic [WIDTH_W-1:0]     pred_width;
    logic [HEIGHT_W-1:0]    pred_height;
    logic [7:0]             row_buf_one [MAX_W];
    logic [7:0]             row_buf_two [MAX_W];
    logic [7:0]             win [3][3];
    int unsigned            col_pos;
    int unsigned            row_pos;

    sobel_res_t             pending_results[$];
    int                     mismatches;
    int                     results_seen;
    int                     edge_results;
    int                     frames_seen;
    int unsigned            cycle_count;
    bit                     no_idle;
    bit                     hold_off_req;

    stim_row_t              dir_rows[$];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Integer square root by bit-pair method.
    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res  = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Advance the Sobel predictor by one pixel and return its result.
    function automatic sobel_res_t sobel_predict(logic [7:0] px);
        sobel_res_t  r;
        int unsigned w;
        int unsigned h;
        int unsigned c;
        logic [$clog2(MAX_W)-1:0] ci;
        int          gx;
        int          gy;
        w = 32'(pred_width);
        h = 32'(pred_height);
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        if (h < 3) h = 3;
        c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        ci = c[$clog2(MAX_W)-1:0];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = row_buf_two[ci];
        win[1][2] = row_buf_one[ci];
        win[2][2] = px;
        row_buf_two[ci] = row_buf_one[ci];
        row_buf_one[ci] = px;
        r.valid_res = (row_pos >= 2) && (c >= 2);
        r.frame_end = (c >= w - 1) && (row_pos >= h - 1);
        r.grad_x    = '0;
        r.grad_y    = '0;
        r.magnitude = '0;
        if (r.valid_res) begin
            gx = win[0][2] - win[0][0] + 2 * (win[1][2] - win[1][0])
                 + win[2][2] - win[2][0];
            gy = win[2][0] + 2 * win[2][1] + win[2][2]
                 - win[0][0] - 2 * win[0][1] - win[0][2];
            r.grad_x    = gx[GRAD_W-1:0];
            r.grad_y    = gy[GRAD_W-1:0];
            r.magnitude = MAG_W'(int_sqrt(gx * gx + gy * gy));
        end
        if (c >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : ((row_pos + 1) & 16'hFFFF);
        end else begin
            col_pos = c + 1;
        end
        return r;
    endfunction

    // Write one size register and mirror it; the block must be idle.
    task automatic write_size(input logic idx, input int unsigned value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH) pred_width = value[WIDTH_W-1:0];
        else pred_height = value[HEIGHT_W-1:0];
    endtask

    // Offer one pixel and wait for its transaction; predict on acceptance.
    task automatic send_pixel(input logic [7:0] px, input bit has_exp,
                              input sobel_res_t exp_r);
        sobel_res_t p;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        p = sobel_predict(px);
        if (has_exp && p != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("directed row disagrees with predictor for pixel %0d", px);
        end
        pending_results.push_back(p);
    endtask

    // Stop offering, then wait until every expected result has come back, plus a margin.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Send a whole frame of pixels: random bytes, random black or white, or dark left and bright right halves.
    task automatic send_frame(input int unsigned w, input int unsigned h, input int style);
        sobel_res_t none;
        logic [7:0] px;
        none = '{default: '0};
        for (int n = 0; n < w * h; n++) begin
            case (style)
                0: px = 8'($urandom_range(0, 255));
                1: px = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: px = (n % w < w / 2) ? 8'h00 : 8'hFF;
            endcase
            send_pixel(px, 1'b0, none);
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Result checker: compares each transaction with the oldest expectation.
    always @(posedge aclk) begin
        sobel_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
            end else begin
                e = pending_results.pop_front();
                if (e.valid_res) edge_results++;
                if (e.frame_end) frames_seen++;
                if (m_tuser !== e.valid_res || m_tlast !== e.frame_end ||
                    m_tdata[10:0] !== e.grad_x || m_tdata[21:11] !== e.grad_y ||
                    m_tdata[32:22] !== e.magnitude || m_tdata[39:33] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp v=%0b gx=%h gy=%h mag=%0d fe=%0b",
                                  " got v=%0b gx=%h gy=%h mag=%0d fe=%0b"},
                                 e.valid_res, e.grad_x, e.grad_y, e.magnitude,
                                 e.frame_end, m_tuser, m_tdata[10:0], m_tdata[21:11],
                                 m_tdata[32:22], m_tlast);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLE) begin
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus and run control.
    initial begin
        sobel_res_t none;
        sobel_res_t z;
        none = '{default: '0};
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_IMAGE_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        mismatches = 0; results_seen = 0; edge_results = 0; frames_seen = 0;
        cycle_count = 0; no_idle = 1'b0; hold_off_req = 1'b0;
        pred_width = WIDTH_W'(1024); pred_height = HEIGHT_W'(1024);
        for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
        col_pos = 0; row_pos = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table on two 3x3 frames: in each, the first pixels give no window; the last pixel
        // is the only full window and ends the frame.
        write_size(CFG_IMAGE_WIDTH, 3);
        write_size(CFG_IMAGE_HEIGHT, 3);
        for (int n = 0; n < 8; n++) begin
            z = none;
            dir_rows.push_back('{pixel: (n % 2) ? 8'hFF : 8'h00, has_exp: 1'b1, exp_res: z});
        end
        // Window 0,FF,0 / FF,0,FF / 0,FF,0 has zero gradients.
        z = none; z.valid_res = 1'b1; z.frame_end = 1'b1;
        dir_rows.push_back('{pixel: 8'h00, has_exp: 1'b1, exp_res: z});
        // Left dark, right bright: the strongest horizontal edge, gx = 1020.
        for (int n = 0; n < 9; n++) begin
            z = none;
            if (n == 8) begin
                z.valid_res = 1'b1; z.frame_end = 1'b1;
                z.grad_x = 11'd1020; z.magnitude = 11'd1020;
            end
            dir_rows.push_back('{pixel: (n % 3 == 2) ? 8'hFF : 8'h00, has_exp: 1'b1,
                                 exp_res: z});
        end
        foreach (dir_rows[k])
            send_pixel(dir_rows[k].pixel, dir_rows[k].has_exp, dir_rows[k].exp_res);
        drain();

        // Out-of-range sizes saturate to the minimum frame.
        write_size(CFG_IMAGE_WIDTH, 0);
        write_size(CFG_IMAGE_HEIGHT, 1);
        send_frame(3, 3, 1);
        drain();

        // Random frames over several sizes.
        write_size(CFG_IMAGE_WIDTH, 7);
        write_size(CFG_IMAGE_HEIGHT, 6);
        send_frame(7, 6, 0);
        send_frame(7, 6, 2);
        hold_off_req = 1'b1;
        send_frame(7, 6, 1);
        drain();
        write_size(CFG_IMAGE_WIDTH, 1024);
        write_size(CFG_IMAGE_HEIGHT, 3);
        send_frame(1024, 1, 0);   // one long row; frame left open
        drain();
        write_size(CFG_IMAGE_WIDTH, 2047);  // saturates to the maximum
        send_frame(200, 1, 0);    // part of the next row; the row stays open
        drain();
        write_size(CFG_IMAGE_WIDTH, 3);     // the open row ends at once
        write_size(CFG_IMAGE_HEIGHT, 65535);
        send_frame(3, 8, 0);      // a tall frame started, then resized
        drain();
        write_size(CFG_IMAGE_WIDTH, 5);
        write_size(CFG_IMAGE_HEIGHT, 4);
        for (int f = 0; f < 6; f++) send_frame(5, 4, $urandom_range(0, 2));
        no_idle = 1'b1;
        for (int f = 0; f < 4; f++) send_frame(5, 4, 0);
        drain();

        $display("Covered %0d results, %0d full windows, %0d frame ends, widths 3..1024.",
                 results_seen, edge_results, frames_seen);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
